### rtl/madc_pkg.sv
// Shared types and constants for the multiplexed ADC scanner.
// Holds scan geometry, register indexes, mode codes and channel payload types.
// No dependencies.
`timescale 1ns / 1ps

package madc_pkg;

   // Scan geometry.
   localparam int MUX_COUNT  = 2;
   localparam int MUX_INPUTS = 16;
   localparam int CHANNELS   = 32;

   localparam int MUX_W  = (MUX_COUNT > 1) ? $clog2(MUX_COUNT) : 1;
   localparam int IN_W   = $clog2(MUX_INPUTS);
   localparam int IDX_W  = $clog2(CHANNELS);
   // Wide enough for any scan or read channel number.
   localparam int CMP_W  = 8;

   localparam int ACC_W   = 16;
   localparam int VALUE_W = 10;
   localparam int PASS_W  = 5;

   localparam logic [ACC_W-1:0]   ACC_MAX   = 16'hFFFF;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1023;
   localparam logic [PASS_W-1:0]  PASS_MAX  = 5'd31;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_SHIFT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_TARGET     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESHOLD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_ADDITION   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_SUBTRACTION = 3'd5;

   // Transaction modes.
   localparam logic [1:0] MODE_SAMPLE  = 2'd0;
   localparam logic [1:0] MODE_READ    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [9:0] sample;
      logic [4:0] channel;
   } madc_req_type;

   typedef struct packed {
      logic [9:0] value;
      logic       data_ready;
      logic       next_mux;
      logic [3:0] next_mux_input;
   } madc_rsp_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic load;
      logic apply;
   } madc_cmd_type;

endpackage

### rtl/mux_adc_scan_edge_hysteresis.sv
// Multiplexed ADC scanner with per-channel oversampling and edge hysteresis.
// Instantiates the sequencer madc_ctrl and the datapath madc_dp; uses madc_pkg.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   req_data.mode selects a conversion result (added to the channel under scan,
//   then the scan position steps; dropped once the pass target is reached), a
//   channel read (shifted, clamped, hysteresis applied, accumulator cleared) or
//   a restart of the scan. Every transaction gives one response: rsp_valid is
//   high for exactly one cycle with rsp_data, after the sequencer captures the
//   transaction, fetches the accumulator entry and writes it back. busy is
//   high during the fetch and write-back, so a new transaction is taken only
//   once the last one has been written back.
//   The response is held in an output register and cannot be stalled.
//   Configuration registers are written through csr_we/csr_index/csr_wdata
//   at any edge, and should only change while the block is idle.
//   Synchronous reset restores the register defaults, clears all
//   accumulators, hysteresis flags and scan counters at once.
`timescale 1ns / 1ps

module mux_adc_scan_edge_hysteresis (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  madc_pkg::madc_req_type req_data,
   output logic                   rsp_valid,
   output madc_pkg::madc_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [9:0]             csr_wdata
);
   import madc_pkg::*;

   madc_cmd_type cmd;

   madc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   madc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Every accepted transaction produces its response.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response missing three cycles after accept");

   // A response is only presented once the sequencer is back at idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while sequencer busy");

   // Responses never come in consecutive cycles.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

endmodule

### rtl/madc_ctrl.sv
// Sequencer for the multiplexed ADC scanner.
// Steps each transaction through capture, accumulator fetch and update.
// Depends on madc_pkg.
`timescale 1ns / 1ps

module madc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output madc_pkg::madc_cmd_type cmd
);
   import madc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.load    = 1'b0;
      cmd.apply   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/madc_dp.sv
// Datapath of the multiplexed ADC scanner: configuration registers, per-channel
// accumulators and hysteresis flags, scan counters and the response register.
// Depends on madc_pkg.
`timescale 1ns / 1ps

module madc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  madc_pkg::madc_cmd_type cmd,
   input  madc_pkg::madc_req_type req_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [9:0]             csr_wdata,
   output logic                   rsp_valid,
   output madc_pkg::madc_rsp_type rsp_data
);
   import madc_pkg::*;

   // Configuration.
   logic [2:0]  shift_ff;
   logic [4:0]  target_ff;
   logic [9:0]  high_thr_ff;
   logic [9:0]  low_thr_ff;
   logic [5:0]  high_add_ff;
   logic [5:0]  low_sub_ff;

   // Channel state.
   logic [ACC_W-1:0] acc_ff [CHANNELS];
   logic [CHANNELS-1:0] high_act_ff;
   logic [CHANNELS-1:0] low_act_ff;
   logic [IN_W-1:0]   scan_in_ff;
   logic [IN_W-1:0]   scan_in_in;
   logic [MUX_W-1:0]  scan_mux_ff;
   logic [MUX_W-1:0]  scan_mux_in;
   logic [PASS_W-1:0] pass_ff;
   logic [PASS_W-1:0] pass_in;

   // Per-transaction registers.
   madc_req_type      req_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              ch_ok_ff;
   logic [ACC_W-1:0]  acc_rd_ff;

   logic              rsp_valid_ff;
   madc_rsp_type      rsp_ff;
   madc_rsp_type      rsp_in;

   // Fetch-stage signals.
   logic [CMP_W-1:0]  scan_ch;
   logic [CMP_W-1:0]  sel_ch;

   // Update-stage signals.
   logic              acc_we;
   logic [ACC_W-1:0]  acc_in;
   logic              flag_we;
   logic              high_act_in;
   logic              low_act_in;
   logic [ACC_W:0]    sum;
   logic [ACC_W-1:0]  sum_sat;
   logic [ACC_W-1:0]  shifted;
   logic [9:0]        level;
   logic signed [11:0] v_s;
   logic signed [11:0] ht_s;
   logic signed [11:0] lt_s;
   logic signed [11:0] add_s;
   logic signed [11:0] sub_s;
   logic [9:0]        up_val;
   logic [9:0]        dn_val;
   logic [9:0]        value;
   logic              in_last;
   logic              mux_last;

   function automatic logic [9:0] clamp10(input logic signed [11:0] v);
      logic [9:0] r;
      if (v < 12'sd0) begin
         r = '0;
      end else if (v > signed'({2'b00, VALUE_MAX})) begin
         r = VALUE_MAX;
      end else begin
         r = v[9:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= 3'd2;
         target_ff   <= 5'd4;
         high_thr_ff <= 10'd1000;
         low_thr_ff  <= 10'd25;
         high_add_ff <= 6'd25;
         low_sub_ff  <= 6'd25;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_SHIFT:    shift_ff    <= csr_wdata[2:0];
            CSR_PASS_TARGET:     target_ff   <= csr_wdata[4:0];
            CSR_HIGH_THRESHOLD:  high_thr_ff <= csr_wdata;
            CSR_LOW_THRESHOLD:   low_thr_ff  <= csr_wdata;
            CSR_HIGH_ADDITION:   high_add_ff <= csr_wdata[5:0];
            CSR_LOW_SUBTRACTION: low_sub_ff  <= csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   // Channel that the transaction touches: the scan position for a
   // conversion, the requested channel for a read.
   assign scan_ch = CMP_W'(scan_mux_ff) * CMP_W'(MUX_INPUTS) + CMP_W'(scan_in_ff);
   assign sel_ch  = (req_ff.mode == MODE_READ) ? CMP_W'(req_ff.channel) : scan_ch;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.load) begin
         idx_ff    <= sel_ch[IDX_W-1:0];
         ch_ok_ff  <= (sel_ch < CMP_W'(CHANNELS));
         acc_rd_ff <= acc_ff[sel_ch[IDX_W-1:0]];
      end
   end

   assign sum     = {1'b0, acc_rd_ff} + (ACC_W + 1)'(req_ff.sample);
   assign sum_sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
   assign shifted = acc_rd_ff >> shift_ff;
   assign level   = (shifted > ACC_W'(VALUE_MAX)) ? VALUE_MAX : shifted[9:0];

   assign v_s   = signed'({2'b00, level});
   assign ht_s  = signed'({2'b00, high_thr_ff});
   assign lt_s  = signed'({2'b00, low_thr_ff});
   assign add_s = signed'({6'b000000, high_add_ff});
   assign sub_s = signed'({6'b000000, low_sub_ff});
   assign up_val = clamp10(v_s + add_s);
   assign dn_val = clamp10(v_s - sub_s);

   assign in_last  = (scan_in_ff == IN_W'(MUX_INPUTS - 1));
   assign mux_last = (scan_mux_ff == MUX_W'(MUX_COUNT - 1));

   always_comb begin
      pass_in     = pass_ff;
      scan_in_in  = scan_in_ff;
      scan_mux_in = scan_mux_ff;
      acc_we      = 1'b0;
      acc_in      = '0;
      flag_we     = 1'b0;
      high_act_in = high_act_ff[idx_ff];
      low_act_in  = low_act_ff[idx_ff];
      value       = '0;
      case (req_ff.mode)
         MODE_SAMPLE: begin
            // Conversions are dropped once the pass target has been reached.
            if (pass_ff < target_ff) begin
               acc_we = ch_ok_ff;
               acc_in = sum_sat;
               if (in_last) begin
                  scan_in_in = '0;
                  if (mux_last) begin
                     scan_mux_in = '0;
                     if (pass_ff < PASS_MAX) begin
                        pass_in = pass_ff + 1'b1;
                     end
                  end else begin
                     scan_mux_in = scan_mux_ff + 1'b1;
                  end
               end else begin
                  scan_in_in = scan_in_ff + 1'b1;
               end
            end
         end
         MODE_READ: begin
            if (ch_ok_ff) begin
               acc_we  = 1'b1;
               flag_we = 1'b1;
               if (v_s > ht_s) begin
                  high_act_in = 1'b1;
                  low_act_in  = 1'b0;
                  value       = up_val;
               end else if (v_s < ht_s - add_s) begin
                  high_act_in = 1'b0;
                  if (v_s < lt_s + sub_s) begin
                     if (v_s < lt_s) begin
                        low_act_in = 1'b1;
                        value      = dn_val;
                     end else if (low_act_ff[idx_ff]) begin
                        value = dn_val;
                     end else begin
                        value = level;
                     end
                  end else begin
                     low_act_in = 1'b0;
                     value      = level;
                  end
               end else if (high_act_ff[idx_ff]) begin
                  value = up_val;
               end else begin
                  value = level;
               end
            end
         end
         MODE_RESTART: begin
            pass_in     = '0;
            scan_in_in  = '0;
            scan_mux_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_in.value          = value;
   assign rsp_in.data_ready     = (pass_in == target_ff);
   assign rsp_in.next_mux       = scan_mux_in[0];
   assign rsp_in.next_mux_input = 4'(scan_in_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            acc_ff[i] <= '0;
         end
         high_act_ff  <= '0;
         low_act_ff   <= '0;
         scan_in_ff   <= '0;
         scan_mux_ff  <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.apply;
         if (cmd.apply) begin
            scan_in_ff  <= scan_in_in;
            scan_mux_ff <= scan_mux_in;
            pass_ff     <= pass_in;
            if (acc_we) begin
               acc_ff[idx_ff] <= acc_in;
            end
            if (flag_we) begin
               high_act_ff[idx_ff] <= high_act_in;
               low_act_ff[idx_ff]  <= low_act_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
